### src/base64_decoder_macros.svh
// ---------------------------------------------------------------------------
// Base64 decoder assertion macros
// Shared concurrent assertion forms for the decoder checkers.
// ---------------------------------------------------------------------------
`ifndef BASE64_DECODER_MACROS_SVH
`define BASE64_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("base64 decoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define B64_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("base64 decoder assertion failed");

`endif

### src/b64_pkg.sv
// ---------------------------------------------------------------------------
// Base64 decoder package
// Request types, the job passed between front and back, and the alphabet map.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b64_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int SEXTET_W    = 6;
    localparam int BUF_W       = 3 * SEXTET_W;
    localparam int WORD_W      = 4 * SEXTET_W;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } enc_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       out_last;
    } dec_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] data;
        logic [1:0]        nbytes;
        logic              last;
    } b64_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } b64_qstat_t;

    typedef struct packed {
        logic                is_alpha;
        logic [SEXTET_W-1:0] value;
    } b64_sextet_t;

    function automatic b64_sextet_t char_value(input logic [7:0] c);
        b64_sextet_t r;
        r.is_alpha = 1'b1;
        r.value    = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.value = SEXTET_W'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A) begin
            r.value = SEXTET_W'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39) begin
            r.value = SEXTET_W'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B) begin
            r.value = SEXTET_W'(62);
        end
        else if (c == 8'h2F) begin
            r.value = SEXTET_W'(63);
        end
        else begin
            r.is_alpha = 1'b0;
        end
        return r;
    endfunction

    // A partial group of k sextets is left aligned; it carries k-1 bytes.
    function automatic b64_job_t partial_job(input logic [BUF_W-1:0] buf_in,
                                             input logic [1:0]       cnt,
                                             input logic             last);
        b64_job_t j;
        j.last = last;
        unique case (cnt)
            2'd2:
            begin
                j.data   = {buf_in[2*SEXTET_W-1:0], {(2*SEXTET_W){1'b0}}};
                j.nbytes = 2'd1;
            end
            2'd3:
            begin
                j.data   = {buf_in, {SEXTET_W{1'b0}}};
                j.nbytes = 2'd2;
            end
            default:
            begin
                j.data   = '0;
                j.nbytes = 2'd0;
            end
        endcase
        return j;
    endfunction

endpackage

`default_nettype wire

### src/b64_front.sv
// ---------------------------------------------------------------------------
// Base64 decoder front end
// Accepts characters, classifies them and builds a byte job when a group fills, at a stop character or at a string end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              enc_valid,
    output logic                   enc_stall,
    input  wire b64_pkg::enc_req_t enc,
    input  wire b64_pkg::b64_qstat_t qstat,
    output logic                   push,
    output b64_pkg::b64_job_t      job
);

    logic [b64_pkg::BUF_W-1:0] buf_reg, buf_next;
    logic [1:0]                cnt_reg, cnt_next;
    logic                      stopped_reg, stopped_next;

    b64_pkg::b64_sextet_t      sx;
    logic [b64_pkg::BUF_W-1:0] buf_acc;
    logic                      accept, acc, full_grp, stop;

    assign enc_stall = qstat.full;
    assign accept    = enc_valid && !enc_stall;

    always_comb
    begin
        sx       = b64_pkg::char_value(enc.in_char);
        acc      = !stopped_reg && sx.is_alpha;
        stop     = !stopped_reg && !sx.is_alpha;
        full_grp = acc && (cnt_reg == 2'd3);
        buf_acc  = {buf_reg[2*b64_pkg::SEXTET_W-1:0], sx.value};

        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        stopped_next = stopped_reg;
        if (accept) begin
            if (enc.in_last || full_grp || stop) begin
                buf_next = '0;
                cnt_next = 2'd0;
            end
            else if (acc) begin
                buf_next = buf_acc;
                cnt_next = cnt_reg + 2'd1;
            end
            stopped_next = enc.in_last ? 1'b0 : (stopped_reg || stop);
        end

        priority if (full_grp) begin
            job.data   = {buf_reg, sx.value};
            job.nbytes = 2'd3;
            job.last   = enc.in_last;
        end
        else if (stop) begin
            job = b64_pkg::partial_job(buf_reg, cnt_reg, enc.in_last);
        end
        else if (acc) begin
            job = b64_pkg::partial_job(buf_acc, cnt_reg + 2'd1, enc.in_last);
            if (!enc.in_last) begin
                job.nbytes = 2'd0;
            end
        end
        else begin
            job.data   = '0;
            job.nbytes = 2'd0;
            job.last   = enc.in_last;
        end

        push = accept && ((job.nbytes != 2'd0) || enc.in_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            buf_reg     <= '0;
            cnt_reg     <= 2'd0;
            stopped_reg <= 1'b0;
        end
        else begin
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

`default_nettype wire

### src/b64_queue.sv
// ---------------------------------------------------------------------------
// Base64 decoder job queue
// Short first-in first-out buffer between the front and back ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64_queue #(
    parameter int DEPTH = b64_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire b64_pkg::b64_job_t  wdata,
    input  wire logic               pop,
    output b64_pkg::b64_job_t       rdata,
    output b64_pkg::b64_qstat_t     qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64_pkg::b64_job_t  mem [DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign qstat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign rdata       = mem[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### src/b64_back.sv
// ---------------------------------------------------------------------------
// Base64 decoder back end
// Holds one job and hands out its bytes, one output request per cycle while dec_stall is low.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire b64_pkg::b64_qstat_t qstat,
    input  wire b64_pkg::b64_job_t   qdata,
    output logic                     pop,
    output logic                     dec_valid,
    input  wire logic                dec_stall,
    output b64_pkg::dec_req_t        dec
);

    b64_pkg::b64_job_t cur_reg, cur_next;
    logic              busy_reg, busy_next;
    logic [1:0]        idx_reg, idx_next;
    logic              final_byte, taken;

    assign dec_valid = busy_reg;

    always_comb
    begin
        final_byte = (cur_reg.nbytes == 2'd0) || (idx_reg == cur_reg.nbytes - 2'd1);
        taken      = busy_reg && !dec_stall;

        dec.byte_valid = (cur_reg.nbytes != 2'd0);
        dec.out_last   = final_byte && cur_reg.last;
        unique case (idx_reg)
            2'd0:    dec.out_byte = cur_reg.data[23:16];
            2'd1:    dec.out_byte = cur_reg.data[15:8];
            default: dec.out_byte = cur_reg.data[7:0];
        endcase
        if (!dec.byte_valid) begin
            dec.out_byte = 8'h00;
        end

        pop       = !qstat.empty && (!busy_reg || (taken && final_byte));
        cur_next  = cur_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop) begin
            cur_next  = qdata;
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end
        else if (taken) begin
            if (final_byte) begin
                busy_next = 1'b0;
            end
            else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

`default_nettype wire

### src/base64_decoder.sv
// ---------------------------------------------------------------------------
// Base64 decoder
// Streaming decoder for the standard alphabet, one character per request.
// ---------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  enc       enc_valid, enc_stall   in_char, in_last
//  dec       dec_valid, dec_stall   out_byte, byte_valid, out_last
//
//  A character is taken every cycle unless the job queue is full.
//  A character yields zero to three output requests; the back end sends one
//  per cycle while dec_stall is low, and a job passes through the queue and
//  the back end's job register before its first byte is offered. The queue
//  decouples the two sides, so output stalls reach the input only once the
//  queue fills. Reset clears the group, the stop flag and the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module base64_decoder #(
    parameter int QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              enc_valid,
    output logic                   enc_stall,
    input  wire b64_pkg::enc_req_t enc,
    output logic                   dec_valid,
    input  wire logic              dec_stall,
    output b64_pkg::dec_req_t      dec
);

    b64_pkg::b64_qstat_t qstat;
    b64_pkg::b64_job_t   job_in, job_out;
    logic                push, pop;

    b64_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc_valid (enc_valid),
        .enc_stall (enc_stall),
        .enc       (enc),
        .qstat     (qstat),
        .push      (push),
        .job       (job_in)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (job_in),
        .pop   (pop),
        .rdata (job_out),
        .qstat (qstat)
    );

    b64_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .qdata     (job_out),
        .pop       (pop),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec       (dec)
    );

endmodule

`default_nettype wire

### src/b64_checker.sv
// ---------------------------------------------------------------------------
// Base64 decoder checker
// Port-level assertions, bound to the decoder top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "base64_decoder_macros.svh"

module b64_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              enc_valid,
    input wire logic              enc_stall,
    input wire b64_pkg::enc_req_t enc,
    input wire logic              dec_valid,
    input wire logic              dec_stall,
    input wire b64_pkg::dec_req_t dec
);

    `B64_ASSERT_NEXT(a_dec_hold, clk, rst_n, dec_valid && dec_stall, dec_valid && $stable(dec))
    `B64_ASSERT_SAME(a_bare_is_last, clk, rst_n, dec_valid && !dec.byte_valid, dec.out_last)
    `B64_ASSERT_SAME(a_bare_zero, clk, rst_n, dec_valid && !dec.byte_valid, dec.out_byte == 8'h00)
    `B64_ASSERT_NEXT(a_enc_hold, clk, rst_n, enc_valid && enc_stall, enc_valid && $stable(enc))
    `B64_ASSERT_SAME(a_full_is_busy, clk, rst_n, enc_stall, dec_valid)

endmodule

bind base64_decoder b64_checker u_b64_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .enc_valid (enc_valid),
    .enc_stall (enc_stall),
    .enc       (enc),
    .dec_valid (dec_valid),
    .dec_stall (dec_stall),
    .dec       (dec)
);

`default_nettype wire

### dv/base64_decoder_checker.sv
// ---------------------------------------------------------------------------
// Base64 decoder checker
// Watches both channels and predicts the decoded requests from each accepted
// character. It compares them field by field, in order, and counts failures.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module base64_decoder_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enc_valid,
    input  logic              enc_stall,
    input  b64_pkg::enc_req_t enc,
    input  logic              dec_valid,
    input  logic              dec_stall,
    input  b64_pkg::dec_req_t dec,
    output int                fail_count,
    output int                pending,
    output int                checked
);

    logic [17:0]       grp_bits;
    logic [1:0]        grp_cnt;
    logic              halted;
    b64_pkg::dec_req_t decoded_q[$];

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) return {1'b1, 6'(c - 8'h41)};
        if (c >= 8'h61 && c <= 8'h7A) return {1'b1, 6'(c - 8'h61 + 8'd26)};
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, 6'(c - 8'h30 + 8'd52)};
        if (c == 8'h2B) return {1'b1, 6'd62};
        if (c == 8'h2F) return {1'b1, 6'd63};
        return 7'd0;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        b64_pkg::dec_req_t r;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.out_last   = 1'b0;
        decoded_q.push_back(r);
    endtask

    // A partial group of k sextets carries k-1 bytes, left aligned.
    task automatic flush_group();
        logic [23:0] word;
        word = {6'd0, grp_bits} << (6 * (4 - int'(grp_cnt)));
        if (grp_cnt >= 2'd2) push_byte(word[23:16]);
        if (grp_cnt == 2'd3) push_byte(word[15:8]);
    endtask

    task automatic decode_char(input logic [7:0] c, input logic last);
        logic [6:0]        sx;
        logic [23:0]       word;
        int                base;
        b64_pkg::dec_req_t r;
        sx   = sextet_of(c);
        base = decoded_q.size();
        if (!halted) begin
            if (sx[6]) begin
                if (grp_cnt == 2'd3) begin
                    word = {grp_bits, sx[5:0]};
                    push_byte(word[23:16]);
                    push_byte(word[15:8]);
                    push_byte(word[7:0]);
                    grp_bits = '0;
                    grp_cnt  = '0;
                end
                else begin
                    grp_bits = {grp_bits[11:0], sx[5:0]};
                    grp_cnt  = grp_cnt + 2'd1;
                end
            end
            else begin
                flush_group();
                grp_bits = '0;
                grp_cnt  = '0;
                halted   = 1'b1;
            end
        end
        if (last) begin
            if (!halted) flush_group();
            if (decoded_q.size() == base) begin
                r.out_byte   = 8'd0;
                r.byte_valid = 1'b0;
                r.out_last   = 1'b1;
            end
            else begin
                r = decoded_q.pop_back();
                r.out_last = 1'b1;
            end
            decoded_q.push_back(r);
            grp_bits = '0;
            grp_cnt  = '0;
            halted   = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        b64_pkg::dec_req_t want;
        int                errs;
        errs = 0;
        if (!rst_n) begin
            grp_bits = '0;
            grp_cnt  = '0;
            halted   = 1'b0;
            decoded_q.delete();
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else begin
            if (enc_valid && !enc_stall) decode_char(enc.in_char, enc.in_last);
            if (dec_valid && !dec_stall) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected request: out_byte %h, byte_valid %b, out_last %b",
                           dec.out_byte, dec.byte_valid, dec.out_last);
                    errs++;
                end
                else begin
                    want = decoded_q.pop_front();
                    if (dec.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, got %h", want.out_byte, dec.out_byte);
                        errs++;
                    end
                    if (dec.byte_valid !== want.byte_valid) begin
                        $error("byte_valid: expected %b, got %b",
                               want.byte_valid, dec.byte_valid);
                        errs++;
                    end
                    if (dec.out_last !== want.out_last) begin
                        $error("out_last: expected %b, got %b", want.out_last, dec.out_last);
                        errs++;
                    end
                end
                checked <= checked + 1;
            end
            fail_count <= fail_count + errs;
            pending    <= decoded_q.size();
        end
    end

endmodule

### dv/base64_decoder_tb.sv
// ---------------------------------------------------------------------------
// Base64 decoder testbench
// Feeds directed and random encoded strings under several idle and stall
// mixes, including a long output stall, and reports the checker's verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module base64_decoder_tb;

    localparam int PHASE_ITEMS    = 60;
    localparam int HOLD_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 16;

    logic              clk;
    logic              rst_n;
    logic              enc_valid;
    logic              enc_stall;
    b64_pkg::enc_req_t enc;
    logic              dec_valid;
    logic              dec_stall;
    b64_pkg::dec_req_t dec;

    int fail_count;
    int pending;
    int checked;

    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         holds_asked    = 0;
    int         idle_cycles    = 0;
    int         items_sent     = 0;
    int         strings_sent   = 0;
    logic [7:0] line_q[$];

    base64_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc_valid (enc_valid),
        .enc_stall (enc_stall),
        .enc       (enc),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec       (dec)
    );

    base64_decoder_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .enc_valid  (enc_valid),
        .enc_stall  (enc_stall),
        .enc        (enc),
        .dec_valid  (dec_valid),
        .dec_stall  (dec_stall),
        .dec        (dec),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        int holds_served;
        holds_served = 0;
        dec_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (holds_asked != holds_served) begin
                holds_served = holds_asked;
                dec_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else begin
                dec_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (enc_valid && !enc_stall) || (dec_valid && !dec_stall)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no request accepted for %0d cycles.", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        if (v < 6'd26) return 8'h41 + v;
        if (v < 6'd52) return 8'h61 + v - 8'd26;
        if (v < 6'd62) return 8'h30 + v - 8'd52;
        if (v == 6'd62) return 8'h2B;
        return 8'h2F;
    endfunction

    task automatic send_req(input logic [7:0] c, input logic last);
        b64_pkg::enc_req_t r;
        logic              taken;
        r.in_char = c;
        r.in_last = last;
        enc_valid <= 1'b1;
        enc       <= r;
        do begin
            @(negedge clk);
            taken = !enc_stall;
            @(posedge clk);
        end while (!taken);
        if ($urandom_range(99) < send_idle_pct) begin
            enc_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic send_line();
        bit last;
        for (int i = 0; i < line_q.size(); i++) begin
            last = (i == line_q.size() - 1);
            items_sent++;
            send_req(line_q[i], last);
        end
        line_q.delete();
        strings_sent++;
    endtask

    task automatic load_text(input string txt);
        for (int i = 0; i < txt.len(); i++) line_q.push_back(txt[i]);
    endtask

    task automatic push_symbols(input int n);
        repeat (n) line_q.push_back(b64_symbol(6'($urandom_range(63))));
    endtask

    // Mostly well-formed strings with random content, otherwise noisy or raw ones.
    task automatic build_line();
        int kind;
        int len;
        kind = $urandom_range(99);
        if (kind < 70) begin
            push_symbols(4 * $urandom_range(3));
            case ($urandom_range(4))
                1:
                begin
                    push_symbols(2);
                    load_text("==");
                end
                2:
                begin
                    push_symbols(3);
                    load_text("=");
                end
                3: push_symbols(2);
                4: push_symbols(3);
                default: ;
            endcase
            if (line_q.size() == 0) push_symbols(1);
        end
        else if (kind < 85) begin
            len = $urandom_range(10, 1);
            push_symbols(len);
            line_q[$urandom_range(len - 1)] = 8'($urandom_range(255));
        end
        else begin
            len = $urandom_range(8, 1);
            repeat (len) line_q.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic pause_until_drained();
        enc_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        int goal;
        rst_n     <= 1'b0;
        enc_valid <= 1'b0;
        enc       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_text("AZaz09+/");
        send_line();
        load_text("TWE=x");
        send_line();
        load_text("Q");
        line_q.push_back(8'hFF);
        line_q.push_back(8'h00);
        send_line();
        load_text("TQ");
        send_line();
        load_text("=");
        send_line();
        load_text("AB");
        line_q.push_back(8'h80);
        send_line();
        pause_until_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    holds_asked   <= holds_asked + 1;
                end
                1:
                begin
                    send_idle_pct  = 51;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 51;
                end
                default:
                begin
                    send_idle_pct  = 6;
                    recv_stall_pct = 6;
                end
            endcase
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                build_line();
                send_line();
            end
            pause_until_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending != 0) $error("%0d decoded requests never arrived", pending);
        $display("Decoded %0d characters in %0d strings, %0d output requests checked,",
                 items_sent, strings_sent, checked);
        $display("with padding, stop bytes, end markers, a long output stall and idle mixes.");
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end
        else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/b64_pkg.sv
src/b64_front.sv
src/b64_queue.sv
src/b64_back.sv
src/base64_decoder.sv
src/b64_checker.sv
dv/base64_decoder_checker.sv
dv/base64_decoder_tb.sv
